// ----- design/pressure_moving_average_defines.svh -----
// Assertion macros shared by the pressure moving average RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PRESSURE_MOVING_AVERAGE_DEFINES_SVH
`define PRESSURE_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define PMA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pma: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low)
`define PMA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pma: next-cycle check failed");

`endif

// ----- design/pma_pkg.sv -----
// Package for the pressure moving average: constants, register codes and types.
// No dependencies; used by pma_div and pressure_moving_average.
`timescale 1ns / 1ps
`default_nettype none

package pma_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int AVG_W      = 24;
    localparam int WINDOW_W   = 9;
    localparam int FRAC_W     = 8;

    // Default window store depth
    localparam int MAX_WINDOW_DEFAULT = 256;

    // Register reset values
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 9'd25;

    // Water column scale: 13.595 = 2719 / 200
    localparam int              SCALE_NUM_BITS = 12;
    localparam int              SCALE_BIT_W    = 4;
    localparam logic [SCALE_NUM_BITS-1:0] SCALE_NUM = 12'd2719;
    localparam int              SCALE_DEN      = 200;
    localparam int              PROD_W         = SAMPLE_W + SCALE_NUM_BITS;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH = 1'b0,
        REG_UNIT_SELECT   = 1'b1
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE_GO,
        ST_SCALE_WAIT,
        ST_UPDATE,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_DONE
    } t_state;

    // Divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

// ----- design/pma_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the sample window of pressure_moving_average.
`timescale 1ns / 1ps
`default_nettype none

module pma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- design/pma_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, DW quotient bits per divide.
// Depends on pma_pkg (t_div_status).
`timescale 1ns / 1ps
`default_nettype none

module pma_div #(
    parameter int DW = 32,
    parameter int VW = 9
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output pma_pkg::t_div_status o_stat,
    output logic      [DW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [VW-1:0]     r_rem, n_rem;
    logic [DW-1:0]     r_quo, n_quo;
    logic [VW-1:0]     r_dsr, n_dsr;

    logic [VW:0]       trial;
    logic [VW:0]       diff;
    logic              ge;

    // One restoring step: bring down the next dividend bit, try subtract
    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        ge    = (trial >= {1'b0, r_dsr});
        diff  = trial - {1'b0, r_dsr};
    end

    // Next-value logic
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[VW-1:0] : trial[VW-1:0];
            n_quo = {r_quo[DW-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

`default_nettype wire

// ----- design/pressure_moving_average.sv -----
// Pressure moving average, top level. Uses pma_pkg, pma_ram, pma_div and the defines header.
// Per sample: multiply and divide by 200 for the scale (water column only), window update, mean
// divide and hand-off to the output register, on one serial divider of width DW, with
// DW = max(16+clog2(MAX_WINDOW)+8, 28) (32 at MAX_WINDOW = 256). No new sample is taken until
// the last result is in the output register, so a stalled output holds off the next one.
// Synchronous active-low reset: empty window, window_length 25, mmHg; window RAM not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "pressure_moving_average_defines.svh"

module pressure_moving_average #(
    parameter int MAX_WINDOW = pma_pkg::MAX_WINDOW_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [pma_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pma_pkg::WINDOW_W-1:0]     i_cfg_data,
    // Sample stream in
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] raw_sample
    // Result stream out
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [39:0] o_m_tdata    // [15:0] scaled_sample, [39:16] average_q8
);

    localparam int SW    = pma_pkg::SAMPLE_W;
    localparam int IDXW  = $clog2(MAX_WINDOW);
    localparam int CNTW  = $clog2(MAX_WINDOW + 1);
    localparam int SUMW  = SW + IDXW;
    localparam int LENW  = (CNTW > pma_pkg::WINDOW_W) ? CNTW : pma_pkg::WINDOW_W;
    localparam int MDW   = SUMW + pma_pkg::FRAC_W;
    localparam int DW    = (MDW > pma_pkg::PROD_W) ? MDW : pma_pkg::PROD_W;
    localparam int VW    = (CNTW > 8) ? CNTW : 8;
    localparam int PW    = pma_pkg::PROD_W;
    localparam int BW    = pma_pkg::SCALE_BIT_W;

    pma_pkg::t_state r_state, n_state;

    // Configuration
    logic [pma_pkg::WINDOW_W-1:0] r_window_len, n_window_len;
    logic                         r_unit, n_unit;

    // Window state
    logic [IDXW-1:0] r_widx, n_widx;
    logic [SUMW-1:0] r_sum,  n_sum;
    logic [CNTW-1:0] r_fill, n_fill;

    // Per-sample working registers
    logic [SW-1:0]   r_raw, n_raw;
    logic [PW-1:0]   r_acc, n_acc;
    logic [BW-1:0]   r_bit, n_bit;
    logic [SW-1:0]   r_sample, n_sample;

    // Output register
    logic                      r_out_valid, n_out_valid;
    logic [SW-1:0]             r_out_scaled, n_out_scaled;
    logic [pma_pkg::AVG_W-1:0] r_out_avg, n_out_avg;

    // Sequencer outputs
    logic in_accept;
    logic out_free;
    logic ram_rd_en;
    logic ram_wr_en;
    logic div_start;
    logic div_sel_scale;

    // Derived window values
    logic [LENW-1:0] wl_ext;
    logic [LENW-1:0] eff_len;
    logic [LENW-1:0] fill_ext;
    logic [LENW-1:0] widx_ext;
    logic [LENW-1:0] widx_inc_ext;
    logic            win_full;
    logic            cfg_restart;

    logic [SW-1:0]   ram_rd_data;
    logic [DW-1:0]   div_dividend;
    logic [VW-1:0]   div_divisor;
    logic [DW-1:0]   div_quo;
    pma_pkg::t_div_status div_stat;

    // Effective window length: 0 acts as 1, clamp to MAX_WINDOW
    always_comb begin
        wl_ext = LENW'(r_window_len);
        if (r_window_len == '0) begin
            eff_len = LENW'(1);
        end else if (wl_ext > LENW'(MAX_WINDOW)) begin
            eff_len = LENW'(MAX_WINDOW);
        end else begin
            eff_len = wl_ext;
        end
        fill_ext     = LENW'(r_fill);
        widx_ext     = LENW'(r_widx);
        widx_inc_ext = widx_ext + LENW'(1);
        win_full     = (fill_ext >= eff_len);
    end

    assign out_free    = !r_out_valid || i_m_tready;
    assign in_accept   = i_s_tvalid && o_s_tready;
    assign cfg_restart = i_cfg_wr_en && (i_cfg_index == pma_pkg::REG_WINDOW_LENGTH);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pma_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = r_unit ? pma_pkg::ST_MUL : pma_pkg::ST_UPDATE;
                end
            end
            pma_pkg::ST_MUL: begin
                if (r_bit == BW'(pma_pkg::SCALE_NUM_BITS - 1)) begin
                    n_state = pma_pkg::ST_SCALE_GO;
                end
            end
            pma_pkg::ST_SCALE_GO:   n_state = pma_pkg::ST_SCALE_WAIT;
            pma_pkg::ST_SCALE_WAIT: begin
                if (div_stat.done) begin
                    n_state = pma_pkg::ST_UPDATE;
                end
            end
            pma_pkg::ST_UPDATE:     n_state = pma_pkg::ST_MEAN_GO;
            pma_pkg::ST_MEAN_GO:    n_state = pma_pkg::ST_MEAN_WAIT;
            pma_pkg::ST_MEAN_WAIT: begin
                if (div_stat.done) begin
                    n_state = pma_pkg::ST_DONE;
                end
            end
            pma_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = pma_pkg::ST_IDLE;
                end
            end
            default: n_state = pma_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_s_tready    = (r_state == pma_pkg::ST_IDLE);
        ram_rd_en     = (r_state == pma_pkg::ST_IDLE) && i_s_tvalid;
        ram_wr_en     = (r_state == pma_pkg::ST_UPDATE);
        div_start     = (r_state == pma_pkg::ST_SCALE_GO) || (r_state == pma_pkg::ST_MEAN_GO);
        div_sel_scale = (r_state == pma_pkg::ST_SCALE_GO);
    end

    // Divider operands: product / 200 for scaling, (sum << 8) / fill for the mean
    always_comb begin
        if (div_sel_scale) begin
            div_dividend = DW'(r_acc);
            div_divisor  = VW'(pma_pkg::SCALE_DEN);
        end else begin
            div_dividend = DW'({r_sum, {pma_pkg::FRAC_W{1'b0}}});
            div_divisor  = VW'(r_fill);
        end
    end

    // Datapath next values
    always_comb begin
        n_window_len = r_window_len;
        n_unit       = r_unit;
        n_widx       = r_widx;
        n_sum        = r_sum;
        n_fill       = r_fill;
        n_raw        = r_raw;
        n_acc        = r_acc;
        n_bit        = r_bit;
        n_sample     = r_sample;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_scaled = r_out_scaled;
        n_out_avg    = r_out_avg;

        // Take a new sample
        if (in_accept) begin
            n_raw    = i_s_tdata[SW-1:0];
            n_sample = i_s_tdata[SW-1:0];
            n_acc    = '0;
            n_bit    = '0;
        end

        // Shift-add multiply by 2719, one constant bit per cycle
        if (r_state == pma_pkg::ST_MUL) begin
            if (pma_pkg::SCALE_NUM[r_bit]) begin
                n_acc = r_acc + (PW'(r_raw) << r_bit);
            end
            n_bit = r_bit + 1'b1;
        end

        // Scaled sample with saturation
        if ((r_state == pma_pkg::ST_SCALE_WAIT) && div_stat.done) begin
            n_sample = (|div_quo[DW-1:SW]) ? {SW{1'b1}} : div_quo[SW-1:0];
        end

        // Window update: add new, drop oldest once full
        if (r_state == pma_pkg::ST_UPDATE) begin
            n_sum  = r_sum + SUMW'(r_sample) - (win_full ? SUMW'(ram_rd_data) : '0);
            n_fill = win_full ? r_fill : r_fill + 1'b1;
            n_widx = (widx_inc_ext >= eff_len) ? '0 : r_widx + 1'b1;
        end

        // Hand the result to the output register
        if ((r_state == pma_pkg::ST_DONE) && out_free) begin
            n_out_valid  = 1'b1;
            n_out_scaled = r_sample;
            n_out_avg    = div_quo[pma_pkg::AVG_W-1:0];
        end

        // Register writes; a window length write restarts the window
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                pma_pkg::REG_WINDOW_LENGTH: n_window_len = i_cfg_data;
                pma_pkg::REG_UNIT_SELECT:   n_unit       = i_cfg_data[0];
                default: ;
            endcase
        end
        if (cfg_restart) begin
            n_widx = '0;
            n_sum  = '0;
            n_fill = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pma_pkg::ST_IDLE;
            r_window_len <= pma_pkg::WINDOW_RESET;
            r_unit       <= 1'b0;
            r_widx       <= '0;
            r_sum        <= '0;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_window_len <= n_window_len;
            r_unit       <= n_unit;
            r_widx       <= n_widx;
            r_sum        <= n_sum;
            r_fill       <= n_fill;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_raw        <= n_raw;
        r_acc        <= n_acc;
        r_bit        <= n_bit;
        r_sample     <= n_sample;
        r_out_scaled <= n_out_scaled;
        r_out_avg    <= n_out_avg;
    end

    // Sample window store
    pma_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_widx),
        .i_wr_data (r_sample),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_widx),
        .o_rd_data (ram_rd_data)
    );

    // Shared serial divider
    pma_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_avg, r_out_scaled};

    // Checks
    `PMA_ASSERT_IMPL(a_fill_in_window, i_clk, i_rst_n, 1'b1, fill_ext <= eff_len)
    `PMA_ASSERT_IMPL(a_index_in_window, i_clk, i_rst_n, 1'b1, widx_ext < eff_len)
    `PMA_ASSERT_NEXT(a_div_runs, i_clk, i_rst_n, div_start, div_stat.busy)
    `PMA_ASSERT_IMPL(a_mean_divisor, i_clk, i_rst_n, r_state == pma_pkg::ST_MEAN_GO, r_fill != '0)

endmodule

`default_nettype wire

// ----- bench/tb_pressure_moving_average.sv -----
// Self-checking bench for pressure_moving_average: sample stream in, scaled sample and mean out.
// Depends on pma_pkg and the block RTL; a small scoreboard class tracks the averaging window.
`timescale 1ns / 1ps

module tb_pressure_moving_average;

    localparam int CLK_HALF    = 4;
    localparam int RESET_CYC   = 4;
    localparam int WIN_DEPTH   = pma_pkg::MAX_WINDOW_DEFAULT;
    localparam int unsigned WATER_NUM = 2719;
    localparam int unsigned WATER_DEN = 200;
    localparam int SETTLE_CYC  = 8;
    localparam int TAIL_CYC    = 120;
    localparam int HOLD_CYC    = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int N_PHASES    = 6;

    // one expected result: scaled sample and Q.8 mean
    typedef struct packed {
        logic [pma_pkg::AVG_W-1:0]    avg_q8;
        logic [pma_pkg::SAMPLE_W-1:0] scaled;
    } t_mean_result;

    // Window predictor plus queue of expected results
    class average_scoreboard;
        logic [pma_pkg::SAMPLE_W-1:0] window_ram [WIN_DEPTH];
        int unsigned                  slot_ptr;
        int unsigned                  filled;
        int unsigned                  window_sum;
        logic [pma_pkg::WINDOW_W-1:0] window_len;
        bit                           water_column;
        t_mean_result                 pending_means[$];
        int unsigned                  mismatches;
        int unsigned                  results_checked;
        int unsigned                  samples_noted;

        function new();
            window_len   = pma_pkg::WINDOW_RESET;
            water_column = 1'b0;
            mismatches   = 0;
            results_checked = 0;
            samples_noted   = 0;
            restart();
        endfunction

        function void restart();
            slot_ptr   = 0;
            filled     = 0;
            window_sum = 0;
        endfunction

        // zero acts as one, oversize clamps to the store depth
        function int unsigned span();
            if (window_len == 0) return 1;
            if (window_len > WIN_DEPTH) return WIN_DEPTH;
            return window_len;
        endfunction

        function void write_register(pma_pkg::t_cfg_reg idx,
                                     logic [pma_pkg::WINDOW_W-1:0] data);
            case (idx)
                pma_pkg::REG_WINDOW_LENGTH: begin
                    window_len = data;
                    restart();
                end
                pma_pkg::REG_UNIT_SELECT: water_column = data[0];
                default: ;
            endcase
        endfunction

        function t_mean_result predict_mean(logic [pma_pkg::SAMPLE_W-1:0] raw);
            int unsigned       len;
            int unsigned       sample;
            longint unsigned   q8;
            t_mean_result      res;
            len    = span();
            sample = raw;
            if (water_column) begin
                sample = (32'(raw) * WATER_NUM) / WATER_DEN;
                if (sample > 16'hFFFF) sample = 16'hFFFF;
            end
            if (slot_ptr >= len) slot_ptr = 0;
            window_sum += sample;
            // full window: oldest entry sits at the write slot
            if (filled < len) filled++;
            else window_sum -= window_ram[slot_ptr];
            window_ram[slot_ptr] = sample[pma_pkg::SAMPLE_W-1:0];
            slot_ptr++;
            if (slot_ptr >= len) slot_ptr = 0;
            q8 = (longint'(window_sum) << pma_pkg::FRAC_W) / filled;
            res.scaled = sample[pma_pkg::SAMPLE_W-1:0];
            res.avg_q8 = q8[pma_pkg::AVG_W-1:0];
            return res;
        endfunction

        function void note_sample(logic [pma_pkg::SAMPLE_W-1:0] raw);
            pending_means.push_back(predict_mean(raw));
            samples_noted++;
        endfunction

        function int pending();
            return pending_means.size();
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 100) $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [39:0] word);
            t_mean_result want;
            t_mean_result got;
            got = word;
            results_checked++;
            if (pending_means.size() == 0) begin
                report_mismatch($sformatf("result %h with no sample pending", word));
            end else begin
                want = pending_means.pop_front();
                if (got.scaled !== want.scaled)
                    report_mismatch($sformatf("scaled_sample got %0d want %0d",
                                              got.scaled, want.scaled));
                if (got.avg_q8 !== want.avg_q8)
                    report_mismatch($sformatf("average_q8 got %0d want %0d",
                                              got.avg_q8, want.avg_q8));
            end
        endtask

        task flag_leftovers();
            if (pending_means.size() != 0)
                report_mismatch($sformatf("%0d expected results never arrived",
                                          pending_means.size()));
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [pma_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [pma_pkg::WINDOW_W-1:0]  i_cfg_data;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [15:0]                   i_s_tdata;   // [15:0] raw_sample
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [39:0]                   o_m_tdata;   // [15:0] scaled_sample, [39:16] average_q8

    average_scoreboard sb = new();
    bit          calm = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned reg_writes = 0;
    int unsigned quiet_cycles = 0;

    // per-phase settings: window length, unit select, sample count
    int phase_win [N_PHASES] = '{3, 1, 16, 0, 511, 7};
    int phase_unit[N_PHASES] = '{1, 0, 0, 1, 0, 1};
    int phase_cnt [N_PHASES] = '{30, 20, 40, 15, 265, 30};

    pressure_moving_average dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
    end

    // watchdog: cycles without any sample, result or register write moving
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
                i_m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // register write, leaves at a negedge with no pending assignment
    task write_reg(pma_pkg::t_cfg_reg idx, logic [pma_pkg::WINDOW_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.write_register(idx, data);
        reg_writes++;
        @(negedge i_clk);
    endtask

    // one sample request, with an optional gap ahead of it
    task send_sample(logic [15:0] raw);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= raw;
        @(posedge i_clk);
        while (!(i_s_tvalid && o_s_tready)) @(posedge i_clk);
        sb.note_sample(raw);
        @(negedge i_clk);
    endtask

    // wait until every expected result has been taken
    task drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // mix of extremes, the saturation edge, mid values and full range
    function logic [15:0] pick_raw();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1:       return 16'($urandom_range(4810, 4830));
            2, 3:    return 16'($urandom_range(0, 4820));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int p;
        int k;
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = pma_pkg::REG_WINDOW_LENGTH;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        repeat (RESET_CYC) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // reset defaults: window 25, mmHg
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        drain();

        // water column, only bit 0 of the write counts; around the saturation edge
        write_reg(pma_pkg::REG_UNIT_SELECT, 9'h1FF);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'd4820);
        send_sample(16'd4821);
        send_sample(16'd4819);
        send_sample(16'd1);
        send_sample(16'd200);
        drain();

        // window zero behaves as one
        write_reg(pma_pkg::REG_WINDOW_LENGTH, 9'd0);
        send_sample(16'd1000);
        send_sample(16'd7);
        send_sample(16'hFFFF);
        drain();

        write_reg(pma_pkg::REG_WINDOW_LENGTH, 9'd1);
        write_reg(pma_pkg::REG_UNIT_SELECT, 9'h102);
        send_sample(16'hFFFF);
        send_sample(16'd3);
        drain();

        // window two wraps after two samples
        write_reg(pma_pkg::REG_WINDOW_LENGTH, 9'd2);
        send_sample(16'd10);
        send_sample(16'd21);
        send_sample(16'hFFFF);
        send_sample(16'd5);
        drain();

        // deepest window, then one beyond it
        write_reg(pma_pkg::REG_WINDOW_LENGTH, 9'd256);
        send_sample(16'hFFFF);
        send_sample(16'd1);
        drain();
        write_reg(pma_pkg::REG_WINDOW_LENGTH, 9'd257);
        send_sample(16'd300);
        send_sample(16'hFFFE);
        drain();

        // random phases; long receiver hold-off in the third, no idling in the last
        for (p = 0; p < N_PHASES; p++) begin
            write_reg(pma_pkg::REG_WINDOW_LENGTH, phase_win[p][pma_pkg::WINDOW_W-1:0]);
            write_reg(pma_pkg::REG_UNIT_SELECT, {8'($urandom), phase_unit[p][0]});
            if (p == 2) hold_request = 1'b1;
            if (p == N_PHASES - 1) calm = 1'b1;
            for (k = 0; k < phase_cnt[p]; k++) send_sample(pick_raw());
            drain();
        end

        repeat (TAIL_CYC) @(negedge i_clk);
        sb.flag_leftovers();
        $display("Sent %0d samples over %0d register writes; %0d results checked.",
                 sb.samples_noted, reg_writes, sb.results_checked);
        $display("Windows 0..511 incl. a full 256-sample wrap, both units, saturation edge.");
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
